/* rtl/tdc_fiber_word_unpacker_assert.svh */
// Assertion macros shared by the unpacker RTL.
// Each macro takes a label, the clock, the active-low reset and the
// expressions of one property.
`ifndef TDC_FIBER_WORD_UNPACKER_ASSERT_SVH
`define TDC_FIBER_WORD_UNPACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFWU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unpacker check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TFWU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unpacker check failed one cycle later");

`endif

/* rtl/tfwu_pkg.sv */
`default_nettype none

package tfwu_pkg;

    // Tag codes in bits 31..28 of a readout word.
    localparam logic [3:0] TAG_TRIG  = 4'h2;
    localparam logic [3:0] TAG_LEAD  = 4'h4;
    localparam logic [3:0] TAG_TRAIL = 4'h5;
    localparam logic [3:0] TAG_SKIPA = 4'hA;
    localparam logic [3:0] TAG_GEO   = 4'hC;
    localparam logic [3:0] TAG_SKIPD = 4'hD;
    localparam logic [3:0] TAG_SKIPE = 4'hE;

    localparam logic [6:0] TRAY_LIMIT_RESET = 7'd122;
    localparam logic [7:0] HALF_TRAY_CHANNELS = 8'd96;
    localparam logic [7:0] TDIG_CHANNELS      = 8'd24;

    typedef enum logic [1:0] {
        KIND_LEAD    = 2'd0,
        KIND_TRAIL   = 2'd1,
        KIND_TRIG    = 2'd2,
        KIND_BADTRAY = 2'd3
    } tfwu_kind_t;

    // One input beat.
    typedef struct packed {
        logic [31:0] data_word;
        logic [1:0]  fiber_index;
        logic        fiber_start;
    } tfwu_word_t;

    // One result beat.
    typedef struct packed {
        tfwu_kind_t  result_kind;
        logic [1:0]  fiber_id;
        logic [6:0]  tray_number;
        logic [7:0]  global_channel;
        logic [20:0] tdc_time;
        logic [31:0] raw_word;
    } tfwu_result_t;

    // Geographic and trigger state shared by all fibers.
    typedef struct packed {
        logic       geo_valid;
        logic       half_tray;
        logic [6:0] tray;
        logic       trigger_seen;
    } tfwu_state_t;

endpackage

`default_nettype wire

/* rtl/tfwu_if.sv */
`default_nettype none

// Readout word channel.
interface tfwu_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [1:0]  fiber_index;
    logic        fiber_start;

    modport source (output valid, output data_word, output fiber_index,
                    output fiber_start, input ready);
    modport sink (input valid, input data_word, input fiber_index,
                  input fiber_start, output ready);
endinterface

// Decoded result channel.
interface tfwu_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  fiber_id;
    logic [6:0]  tray_number;
    logic [7:0]  global_channel;
    logic [20:0] tdc_time;
    logic [31:0] raw_word;

    modport source (output valid, output result_kind, output fiber_id,
                    output tray_number, output global_channel, output tdc_time,
                    output raw_word, input ready);
    modport sink (input valid, input result_kind, input fiber_id,
                  input tray_number, input global_channel, input tdc_time,
                  input raw_word, output ready);
endinterface

`default_nettype wire

/* rtl/tdc_fiber_word_unpacker.sv */
// Readout word unpacker for a time-of-flight TDC fiber link.
// Channels: word_ch (sink) takes one 32-bit readout word per beat together
// with its fiber index and a fiber start flag; result_ch (source) gives the
// decoded beats: leading hit, trailing hit, first trigger time of a fiber
// or a bad tray report. A word yields zero or one result beat.
// cfg_we/cfg_wdata write the tray limit, the largest accepted tray id. The
// user must write it only while the block is idle; the block does not enforce it.
// A word is registered in the input register at acceptance, decoded from
// there, and its result is held in the output register. Throughput is one
// word per cycle unless a stalled receiver holds back a word with a result,
// set by the single decode stage between the input and output registers.
// Reset clears both stages, the fiber state and sets the tray limit to 122.
// When the receiver stalls, the output register holds its beat, and a word
// that needs that register waits in the input register; words that give no
// result still pass. word_ch.ready falls only when both registers are full
// and the waiting word has a result.
`default_nettype none

module tdc_fiber_word_unpacker #(
    parameter int unsigned FIBER_COUNT = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,
    tfwu_word_if.sink        word_ch,
    tfwu_result_if.source    result_ch
);
    import tfwu_pkg::*;

    logic [6:0]   tray_limit_q_reg;
    logic         s1_valid_reg;
    tfwu_word_t   s1_word_reg;
    tfwu_state_t  state_reg;
    tfwu_state_t  state_next;
    logic         out_valid_reg;
    tfwu_result_t out_data_reg;
    tfwu_result_t dec_result;
    logic         dec_emit;
    logic         fiber_ok;
    logic         out_free;
    logic         s1_move;
    logic         word_accept;

    // Configuration register holding the tray limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tray_limit_q_reg <= TRAY_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            tray_limit_q_reg <= cfg_wdata;
        end
    end

    // Handshake between the two stages.
    always_comb
    begin
        fiber_ok      = (5'(s1_word_reg.fiber_index) < 5'(FIBER_COUNT))
                        || (FIBER_COUNT > 4);
        out_free      = !out_valid_reg || result_ch.ready;
        s1_move       = s1_valid_reg && (!dec_emit || out_free);
        word_ch.ready = !s1_valid_reg || s1_move;
        word_accept   = word_ch.valid && word_ch.ready;
    end

    tfwu_decode u_decode (
        .word       (s1_word_reg),
        .fiber_ok   (fiber_ok),
        .state      (state_reg),
        .tray_limit (tray_limit_q_reg),
        .emit       (dec_emit),
        .result     (dec_result),
        .state_next (state_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (word_ch.ready)
        begin
            s1_valid_reg <= word_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_accept)
        begin
            s1_word_reg.data_word   <= word_ch.data_word;
            s1_word_reg.fiber_index <= word_ch.fiber_index;
            s1_word_reg.fiber_start <= word_ch.fiber_start;
        end
    end

    // Fiber state advances as each word leaves the decode stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_move)
        begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_move && dec_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && dec_emit)
        begin
            out_data_reg <= dec_result;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.result_kind    = out_data_reg.result_kind;
    assign result_ch.fiber_id       = out_data_reg.fiber_id;
    assign result_ch.tray_number    = out_data_reg.tray_number;
    assign result_ch.global_channel = out_data_reg.global_channel;
    assign result_ch.tdc_time       = out_data_reg.tdc_time;
    assign result_ch.raw_word       = out_data_reg.raw_word;

`include "tdc_fiber_word_unpacker_assert.svh"

    // An accepted word is always held in the input register next cycle.
    `TFWU_ASSERT_NEXT(a_word_held, clk, rst_n, word_accept, s1_valid_reg)

    // A waiting result word with a blocked output must stall the input.
    `TFWU_ASSERT_SAME(a_stall_back, clk, rst_n,
        s1_valid_reg && dec_emit && out_valid_reg && !result_ch.ready,
        !word_ch.ready && !s1_move)

    // A decoded result lands in the output register with its kind.
    `TFWU_ASSERT_NEXT(a_result_kind, clk, rst_n, s1_move && dec_emit,
        out_valid_reg && (out_data_reg.result_kind == $past(dec_result.result_kind)))

    // A trigger result is reported at most once until the next fiber start.
    `TFWU_ASSERT_SAME(a_trig_once, clk, rst_n,
        s1_move && dec_emit && (dec_result.result_kind == KIND_TRIG),
        s1_word_reg.fiber_start || !state_reg.trigger_seen)

endmodule

`default_nettype wire

/* rtl/tfwu_decode.sv */
`default_nettype none

module tfwu_decode (
    input  tfwu_pkg::tfwu_word_t   word,
    input  logic                   fiber_ok,
    input  tfwu_pkg::tfwu_state_t  state,
    input  logic [6:0]             tray_limit,
    output logic                   emit,
    output tfwu_pkg::tfwu_result_t result,
    output tfwu_pkg::tfwu_state_t  state_next
);
    import tfwu_pkg::*;

    logic [3:0]  tag;
    logic [3:0]  tdc_id;
    tfwu_state_t st;
    logic [7:0]  channel;
    logic [20:0] time_value;
    logic        tray_bad;

    // Fields of the word and the state after an optional fiber start.
    always_comb
    begin
        tag        = word.data_word[31:28];
        tdc_id     = word.data_word[27:24];
        st         = word.fiber_start ? '0 : state;
        channel    = 8'(word.data_word[23:21])
                   + {3'b000, tdc_id[1:0], 3'b000}
                   + 8'(tdc_id[3:2]) * TDIG_CHANNELS
                   + (st.half_tray ? HALF_TRAY_CHANNELS : 8'd0);
        // The 19 low bits move up by two and bits 20..19 fill the gap.
        time_value = {word.data_word[18:0], word.data_word[20:19]};
        tray_bad   = (st.tray == 7'd0) || (st.tray > tray_limit);
    end

    // Tag decode and state update.
    always_comb
    begin
        emit                  = 1'b0;
        state_next            = st;
        result.result_kind    = KIND_LEAD;
        result.fiber_id       = word.fiber_index;
        result.tray_number    = st.tray;
        result.global_channel = 8'd0;
        result.tdc_time       = 21'd0;
        result.raw_word       = word.data_word;

        if (!fiber_ok)
        begin
            // A word from a fiber that does not exist leaves everything alone.
            state_next = state;
        end
        else
        begin
            unique case (tag) inside
                TAG_SKIPA, TAG_SKIPD, TAG_SKIPE:
                begin
                end
                TAG_TRIG:
                begin
                    if (!st.trigger_seen)
                    begin
                        emit                    = 1'b1;
                        state_next.trigger_seen = 1'b1;
                        result.result_kind      = KIND_TRIG;
                        result.tray_number      = 7'd0;
                    end
                end
                TAG_GEO:
                begin
                    state_next.half_tray = word.data_word[0];
                    state_next.tray      = word.data_word[7:1];
                    state_next.geo_valid = 1'b1;
                end
                default:
                begin
                    if (st.geo_valid)
                    begin
                        if (tray_bad)
                        begin
                            emit               = 1'b1;
                            result.result_kind = KIND_BADTRAY;
                        end
                        else if (tag == TAG_LEAD || tag == TAG_TRAIL)
                        begin
                            emit                  = 1'b1;
                            result.result_kind    = (tag == TAG_LEAD) ? KIND_LEAD
                                                                      : KIND_TRAIL;
                            result.global_channel = channel;
                            result.tdc_time       = time_value;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire
